// File: rtl/core/crcf_pkg.sv
`default_nettype none

package crcf_pkg;

  localparam int WINDOW_COLORS = 16;
  localparam int RAMP_COLORS   = 42;

  localparam int POS_W   = 6;
  localparam int COUNT_W = 8;
  localparam int DIV_W   = 3;
  localparam int STRIP_W = 5;
  localparam int FADE_W  = 6;
  localparam int COLOR_W = 16;
  localparam int SLOT_W  = 4;
  localparam int CFG_W   = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_DIVIDER   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_START_STRIP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNDERFLOW_POLICY = 2'd2;

  localparam logic [DIV_W-1:0]   SCROLL_DIVIDER_RESET   = 3'd4;
  localparam logic [STRIP_W-1:0] TEXT_START_STRIP_RESET = 5'd21;

  localparam logic [COLOR_W-1:0] BORROW_ALL = 16'h1110;
  localparam logic [COLOR_W-1:0] FIELD_R    = 16'h001E;
  localparam logic [COLOR_W-1:0] FIELD_G    = 16'h01E0;
  localparam logic [COLOR_W-1:0] FIELD_B    = 16'h1E00;

  typedef logic [COLOR_W-1:0] color_t;

  function automatic logic [11:0] ramp_color(input logic [POS_W-1:0] idx);
    logic [11:0] c;
    unique case (idx)
      6'd0:  c = 12'hE00;  6'd1:  c = 12'hE02;  6'd2:  c = 12'hE04;
      6'd3:  c = 12'hE06;  6'd4:  c = 12'hE08;  6'd5:  c = 12'hE0A;
      6'd6:  c = 12'hE0C;  6'd7:  c = 12'hE0E;  6'd8:  c = 12'hC0E;
      6'd9:  c = 12'hA0E;  6'd10: c = 12'h80E;  6'd11: c = 12'h60E;
      6'd12: c = 12'h40E;  6'd13: c = 12'h20E;  6'd14: c = 12'h00E;
      6'd15: c = 12'h02E;  6'd16: c = 12'h04E;  6'd17: c = 12'h06E;
      6'd18: c = 12'h08E;  6'd19: c = 12'h0AE;  6'd20: c = 12'h0CE;
      6'd21: c = 12'h0EE;  6'd22: c = 12'h0EC;  6'd23: c = 12'h0EA;
      6'd24: c = 12'h0E8;  6'd25: c = 12'h0E6;  6'd26: c = 12'h0E4;
      6'd27: c = 12'h0E2;  6'd28: c = 12'h0E0;  6'd29: c = 12'h2E0;
      6'd30: c = 12'h4E0;  6'd31: c = 12'h6E0;  6'd32: c = 12'h8E0;
      6'd33: c = 12'hAE0;  6'd34: c = 12'hCE0;  6'd35: c = 12'hEE0;
      6'd36: c = 12'hEC0;  6'd37: c = 12'hEA0;  6'd38: c = 12'hE80;
      6'd39: c = 12'hE60;  6'd40: c = 12'hE40;  6'd41: c = 12'hE20;
      default: c = 12'h000;
    endcase
    return c;
  endfunction

  // The fade level n stands for a fade of 0x222 * n, capped at seven steps.
  // Each nibble of 0x222 * m is 2 * m, so the product is built by wiring.
  function automatic color_t fade_color(input logic [POS_W-1:0] idx,
                                        input logic [FADE_W-1:0] n,
                                        input logic policy);
    logic [2:0] m;
    color_t sub;
    color_t d;
    m = (n >= FADE_W'(7)) ? 3'd7 : n[2:0];
    sub = {4'h0, m, 1'b0, m, 1'b0, m, 1'b0};
    d = {4'h0, ramp_color(idx)} - sub;
    if (policy) begin
      if ((d & BORROW_ALL) != '0) d = '0;
    end else begin
      if (d[4])  d = d & ~FIELD_R;
      if (d[8])  d = d & ~FIELD_G;
      if (d[12]) d = d & ~FIELD_B;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/color_ramp_cycler_with_fade_core.sv
`default_nettype none
// Each accepted strip gives WINDOW_COLORS colors, one per cycle while the output is not stalled.
// After the transfer, the bit-serial divider in ST_DIV finds the window start one quotient bit
// per step, ST_LOAD loads the first color, and ST_EMIT then shows it.
// A new strip is taken only in ST_IDLE, once the last color of the window has been transferred.
// Reset is synchronous: state and frame counter clear, and config registers take their reset values.
module color_ramp_cycler_with_fade_core #(
  parameter int WINDOW_COLORS = crcf_pkg::WINDOW_COLORS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [crcf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [crcf_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                           item_valid,
  output logic                                item_stall,
  input  wire logic [crcf_pkg::STRIP_W-1:0]   fading_strip,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output logic [crcf_pkg::COLOR_W-1:0]        color,
  output logic [crcf_pkg::SLOT_W-1:0]         slot,
  output logic                                last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  localparam logic [crcf_pkg::SLOT_W-1:0] LAST_SLOT = crcf_pkg::SLOT_W'(WINDOW_COLORS - 1);
  localparam logic [1:0] LAST_SLOT_LO = 2'(WINDOW_COLORS - 1);
  localparam logic [crcf_pkg::POS_W-1:0] LAST_POS = crcf_pkg::POS_W'(crcf_pkg::RAMP_COLORS - 1);

  logic [1:0] state;
  logic [crcf_pkg::DIV_W-1:0] scroll_divider;
  logic [crcf_pkg::STRIP_W-1:0] text_start_strip;
  logic underflow_policy;
  logic [crcf_pkg::COUNT_W-1:0] frame_count;
  logic [crcf_pkg::COUNT_W-1:0] quot;
  logic [crcf_pkg::DIV_W-1:0] rem;
  logic [2:0] step;
  logic [crcf_pkg::POS_W-1:0] pos;
  logic [crcf_pkg::FADE_W-1:0] fade;

  logic [crcf_pkg::DIV_W-1:0] divisor;
  logic [crcf_pkg::DIV_W:0] rem_sh;
  logic [crcf_pkg::DIV_W:0] rem_diff;
  logic fits;
  logic [crcf_pkg::COUNT_W-1:0] quot_next;
  logic [crcf_pkg::FADE_W-1:0] fade_init;
  logic [crcf_pkg::POS_W-1:0] pos_next;
  logic [crcf_pkg::FADE_W-1:0] fade_next;
  logic item_xfer;
  logic result_xfer;

  assign divisor  = (scroll_divider == '0) ? crcf_pkg::DIV_W'(1) : scroll_divider;
  assign rem_sh   = {rem, quot[crcf_pkg::COUNT_W-1]};
  assign rem_diff = rem_sh - {1'b0, divisor};
  assign fits     = rem_sh >= {1'b0, divisor};
  assign quot_next = {quot[crcf_pkg::COUNT_W-2:0], fits};

  assign fade_init = (fading_strip >= text_start_strip)
                   ? crcf_pkg::FADE_W'({1'b0, fading_strip} - {1'b0, text_start_strip})
                     + crcf_pkg::FADE_W'(1)
                   : '0;

  assign pos_next  = (pos == LAST_POS) ? '0 : pos + crcf_pkg::POS_W'(1);
  assign fade_next = ((LAST_SLOT_LO - slot[1:0]) == 2'd0 && fade != '0)
                   ? fade - crcf_pkg::FADE_W'(1) : fade;

  assign item_stall   = (state != ST_IDLE);
  assign result_valid = (state == ST_EMIT);
  assign last         = (slot == LAST_SLOT);
  assign item_xfer    = item_valid && !item_stall;
  assign result_xfer  = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_divider   <= crcf_pkg::SCROLL_DIVIDER_RESET;
      text_start_strip <= crcf_pkg::TEXT_START_STRIP_RESET;
      underflow_policy <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        crcf_pkg::CFG_SCROLL_DIVIDER:   scroll_divider   <= cfg_data[crcf_pkg::DIV_W-1:0];
        crcf_pkg::CFG_TEXT_START_STRIP: text_start_strip <= cfg_data;
        crcf_pkg::CFG_UNDERFLOW_POLICY: underflow_policy <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      frame_count <= '0;
      step        <= '0;
      slot        <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (item_xfer) begin
            quot  <= frame_count;
            rem   <= '0;
            step  <= '0;
            fade  <= fade_init;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          quot <= quot_next;
          rem  <= fits ? rem_diff[crcf_pkg::DIV_W-1:0] : rem_sh[crcf_pkg::DIV_W-1:0];
          step <= step + 3'd1;
          if (step == 3'd7) begin
            if (quot_next >= crcf_pkg::COUNT_W'(crcf_pkg::RAMP_COLORS)) begin
              pos         <= '0;
              frame_count <= '0;
            end else begin
              pos         <= quot_next[crcf_pkg::POS_W-1:0];
              frame_count <= frame_count + crcf_pkg::COUNT_W'(1);
            end
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          color <= crcf_pkg::fade_color(pos, fade, underflow_policy);
          slot  <= '0;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (result_xfer) begin
            if (last) begin
              state <= ST_IDLE;
            end else begin
              pos   <= pos_next;
              fade  <= fade_next;
              slot  <= slot + crcf_pkg::SLOT_W'(1);
              color <= crcf_pkg::fade_color(pos_next, fade_next, underflow_policy);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_busy_when_showing: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> item_stall)
    else $error("input taken while a color is shown");

  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    (result_xfer && last) |=> !result_valid)
    else $error("color shown after the last slot");

  a_slot_steps: assert property (@(posedge clk) disable iff (rst)
    (result_xfer && !last) |=> (result_valid && slot == $past(slot) + crcf_pkg::SLOT_W'(1)))
    else $error("slot did not advance by one");

  a_pos_in_ring: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (pos <= LAST_POS))
    else $error("ramp position outside the ring");

endmodule

`default_nettype wire

// File: test/color_ramp_cycler_with_fade_core_test.sv
`timescale 1ns / 1ps

module color_ramp_cycler_with_fade_core_test;

  localparam logic [crcf_pkg::CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
  localparam int FADE_STEP = 'h222;
  localparam int FADE_CAP = 'hEEE;
  localparam int SETTLE_CYCLES = crcf_pkg::WINDOW_COLORS + 14;

  typedef enum {PACE_FULL, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH} pace_t;

  typedef struct packed {
    crcf_pkg::color_t color;
    logic [crcf_pkg::SLOT_W-1:0] slot;
    logic last;
  } shade_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [crcf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [crcf_pkg::CFG_W-1:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [crcf_pkg::STRIP_W-1:0] fading_strip = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  crcf_pkg::color_t color;
  logic [crcf_pkg::SLOT_W-1:0] slot;
  logic last;

  logic [11:0] gradient [crcf_pkg::RAMP_COLORS] = '{
    12'hE00, 12'hE02, 12'hE04, 12'hE06, 12'hE08, 12'hE0A, 12'hE0C,
    12'hE0E, 12'hC0E, 12'hA0E, 12'h80E, 12'h60E, 12'h40E, 12'h20E,
    12'h00E, 12'h02E, 12'h04E, 12'h06E, 12'h08E, 12'h0AE, 12'h0CE,
    12'h0EE, 12'h0EC, 12'h0EA, 12'h0E8, 12'h0E6, 12'h0E4, 12'h0E2,
    12'h0E0, 12'h2E0, 12'h4E0, 12'h6E0, 12'h8E0, 12'hAE0, 12'hCE0,
    12'hEE0, 12'hEC0, 12'hEA0, 12'hE80, 12'hE60, 12'hE40, 12'hE20
  };

  logic [crcf_pkg::COUNT_W-1:0] frame_cnt = '0;
  logic [crcf_pkg::DIV_W-1:0] divider = crcf_pkg::SCROLL_DIVIDER_RESET;
  logic [crcf_pkg::STRIP_W-1:0] start_strip = crcf_pkg::TEXT_START_STRIP_RESET;
  logic policy = 1'b0;

  shade_t expected_shades[$];
  pace_t pace = PACE_FULL;
  int errors = 0;
  int ticks_sent = 0;
  int colors_checked = 0;
  int reg_writes = 0;

  color_ramp_cycler_with_fade_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .fading_strip(fading_strip),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .color(color),
    .slot(slot),
    .last(last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int idle_pct(input bit sender);
    unique case (pace)
      PACE_SENDER_IDLE: return sender ? 83 : 0;
      PACE_RECEIVER_STALL: return sender ? 0 : 83;
      PACE_BOTH: return 22;
      default: return 0;
    endcase
  endfunction

  function automatic void predict_window(input logic [crcf_pkg::STRIP_W-1:0] strip);
    int fade;
    int div;
    int start;
    int pos;
    int sub;
    crcf_pkg::color_t d;
    shade_t e;
    fade = 0;
    if (strip >= start_strip) begin
      fade = FADE_STEP * (int'(strip) - int'(start_strip) + 1);
    end
    div = (divider == '0) ? 1 : int'(divider);
    start = int'(frame_cnt) / div;
    frame_cnt = frame_cnt + 1'b1;
    if (start >= crcf_pkg::RAMP_COLORS) begin
      start = 0;
      frame_cnt = '0;
    end
    for (int k = 0; k < crcf_pkg::WINDOW_COLORS; k++) begin
      pos = (start + k) % crcf_pkg::RAMP_COLORS;
      sub = (fade < FADE_CAP) ? fade : FADE_CAP;
      d = {4'h0, gradient[pos]} - crcf_pkg::color_t'(sub);
      if (((crcf_pkg::WINDOW_COLORS - 1 - k) & 3) == 0) begin
        fade = (fade > FADE_STEP) ? fade - FADE_STEP : 0;
      end
      if (policy) begin
        if ((d & crcf_pkg::BORROW_ALL) != '0) d = '0;
      end else begin
        if (d[4]) d = d & ~crcf_pkg::FIELD_R;
        if (d[8]) d = d & ~crcf_pkg::FIELD_G;
        if (d[12]) d = d & ~crcf_pkg::FIELD_B;
      end
      e.color = d;
      e.slot = crcf_pkg::SLOT_W'(k);
      e.last = (k == crcf_pkg::WINDOW_COLORS - 1);
      expected_shades.push_back(e);
    end
  endfunction

  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < idle_pct(1'b0));
  end

  always @(posedge clk) begin
    shade_t e;
    if (!rst && result_valid && !result_stall) begin
      if (expected_shades.size() == 0) begin
        $display("%0t: unexpected color transfer: color %h slot %0d last %0b",
                 $time, color, slot, last);
        errors++;
      end else begin
        e = expected_shades.pop_front();
        colors_checked++;
        if (color !== e.color) begin
          $display("%0t: color mismatch: expected %h, actual %h", $time, e.color, color);
          errors++;
        end
        if (slot !== e.slot) begin
          $display("%0t: slot mismatch: expected %0d, actual %0d", $time, e.slot, slot);
          errors++;
        end
        if (last !== e.last) begin
          $display("%0t: last mismatch: expected %0b, actual %0b", $time, e.last, last);
          errors++;
        end
      end
    end
  end

  task automatic send_strip(input logic [crcf_pkg::STRIP_W-1:0] strip);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct(1'b1)) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid = 1'b1;
    fading_strip = strip;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predict_window(strip);
    ticks_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    item_valid = 1'b0;
    while (expected_shades.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [crcf_pkg::CFG_IDX_W-1:0] index,
                           input logic [crcf_pkg::CFG_W-1:0] data);
    settle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = index;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    unique case (index)
      crcf_pkg::CFG_SCROLL_DIVIDER: divider = data[crcf_pkg::DIV_W-1:0];
      crcf_pkg::CFG_TEXT_START_STRIP: start_strip = data[crcf_pkg::STRIP_W-1:0];
      crcf_pkg::CFG_UNDERFLOW_POLICY: policy = data[0];
      default: ;
    endcase
    reg_writes++;
  endtask

  function automatic logic [crcf_pkg::STRIP_W-1:0] pick_strip();
    int s;
    if ($urandom_range(1) == 0) return crcf_pkg::STRIP_W'($urandom_range(31));
    s = int'(start_strip) + int'($urandom_range(9)) - 1;
    if (s < 0) s = 0;
    if (s > 31) s = 31;
    return crcf_pkg::STRIP_W'(s);
  endfunction

  task automatic test_reset_settings();
    send_strip(5'd0);
    send_strip(5'd20);
    send_strip(5'd21);
    send_strip(5'd31);
  endtask

  task automatic test_fade_and_policy();
    write_reg(crcf_pkg::CFG_UNDERFLOW_POLICY, 5'b11111);
    send_strip(5'd31);
    send_strip(5'd24);
    send_strip(5'd21);
    write_reg(crcf_pkg::CFG_TEXT_START_STRIP, 5'd0);
    send_strip(5'd0);
    send_strip(5'd31);
    write_reg(crcf_pkg::CFG_TEXT_START_STRIP, 5'd31);
    send_strip(5'd30);
    send_strip(5'd31);
    write_reg(crcf_pkg::CFG_UNDERFLOW_POLICY, 5'b11110);
    send_strip(5'd31);
    send_strip(5'd3);
  endtask

  task automatic test_divider_values();
    write_reg(crcf_pkg::CFG_SCROLL_DIVIDER, 5'd0);
    send_strip(5'd31);
    send_strip(5'd10);
    write_reg(crcf_pkg::CFG_SCROLL_DIVIDER, 5'd7);
    send_strip(5'd17);
    write_reg(crcf_pkg::CFG_SCROLL_DIVIDER, 5'b11110);
    send_strip(5'd2);
    write_reg(crcf_pkg::CFG_SCROLL_DIVIDER, 5'd1);
    send_strip(5'd31);
  endtask

  task automatic test_unused_register();
    write_reg(CFG_UNUSED_INDEX, 5'h1F);
    send_strip(5'd31);
  endtask

  // A slow divider lets the count run well past the ramp length, so a fast
  // divider afterwards gives a window start beyond the end of the ramp.
  task automatic test_start_past_ramp_end();
    pace = PACE_BOTH;
    write_reg(crcf_pkg::CFG_TEXT_START_STRIP, 5'd12);
    write_reg(crcf_pkg::CFG_SCROLL_DIVIDER, 5'd2);
    while (frame_cnt < 8'd50) send_strip(pick_strip());
    write_reg(crcf_pkg::CFG_SCROLL_DIVIDER, 5'd1);
    send_strip(pick_strip());
    send_strip(pick_strip());
    pace = PACE_FULL;
  endtask

  task automatic test_random_traffic();
    pace_t modes[4];
    int n;
    modes = '{PACE_FULL, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH};
    foreach (modes[m]) begin
      pace = modes[m];
      repeat (4) begin
        n = $urandom_range(1, 3);
        repeat (n) write_reg(crcf_pkg::CFG_IDX_W'($urandom_range(3)),
                             crcf_pkg::CFG_W'($urandom_range(31)));
        repeat (11) send_strip(pick_strip());
      end
    end
    pace = PACE_FULL;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_settings();
    test_fade_and_policy();
    test_divider_values();
    test_unused_register();
    test_start_past_ramp_end();
    test_random_traffic();
    settle();
    $display("Sent %0d frame ticks and checked %0d colors under %0d register writes,",
             ticks_sent, colors_checked, reg_writes);
    $display("covering both underflow policies, divider changes and every pacing mode.");
    if (errors == 0) begin
      $display("color_ramp_cycler_with_fade_core_test passed");
    end else begin
      $display("color_ramp_cycler_with_fade_core_test failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Timed out with %0d colors still expected.", expected_shades.size());
    $display("color_ramp_cycler_with_fade_core_test failed");
    $finish;
  end

endmodule
